>>> hdl/sal8_pkg.sv
// sal8_pkg: shared types, quarter-round word map and helpers for the Salsa20 core pipeline.
// Used by sal8_step, sal8_fin and salsa20_8_core_unit. No dependencies.
package sal8_pkg;

  localparam int WORDS      = 16;
  localparam int PAIRS      = 8;
  localparam int WORD_W     = 32;
  localparam int DEF_ROUNDS = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WORDS-1:0][WORD_W-1:0] block_t;
  typedef logic [3:0] idx_t;

  typedef struct packed {
    block_t w;
    block_t orig;
  } stage_t;

  localparam int unsigned ROT [4] = '{7, 9, 13, 18};

  localparam idx_t QR_IDX [2][4][4] = '{
    '{ '{4'd0,  4'd4,  4'd8,  4'd12}, '{4'd5,  4'd9,  4'd13, 4'd1},
       '{4'd10, 4'd14, 4'd2,  4'd6},  '{4'd15, 4'd3,  4'd7,  4'd11} },
    '{ '{4'd0,  4'd1,  4'd2,  4'd3},  '{4'd5,  4'd6,  4'd7,  4'd4},
       '{4'd10, 4'd11, 4'd8,  4'd9},  '{4'd15, 4'd12, 4'd13, 4'd14} }
  };

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

>>> hdl/salsa20_8_core_unit.sv
// salsa20_8_core_unit: pipelined Salsa20 core, one add-rotate-xor step per stage.
// An accepted block passes each step stage, then sal8_fin, before out_valid.
// Throughput: one block per cycle; a full stage holds until the next takes it.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on sal8_pkg, sal8_step and sal8_fin.
module salsa20_8_core_unit #(
  parameter int ROUNDS = sal8_pkg::DEF_ROUNDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_pair_0,
  input  logic [63:0] in_pair_1,
  input  logic [63:0] in_pair_2,
  input  logic [63:0] in_pair_3,
  input  logic [63:0] in_pair_4,
  input  logic [63:0] in_pair_5,
  input  logic [63:0] in_pair_6,
  input  logic [63:0] in_pair_7,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_pair_0,
  output logic [63:0] out_pair_1,
  output logic [63:0] out_pair_2,
  output logic [63:0] out_pair_3,
  output logic [63:0] out_pair_4,
  output logic [63:0] out_pair_5,
  output logic [63:0] out_pair_6,
  output logic [63:0] out_pair_7
);

  localparam int NSTEP = 4 * ROUNDS;

  sal8_pkg::stage_t sdata [NSTEP+1];
  logic [NSTEP:0]   svalid;
  logic [NSTEP:0]   sready;
  sal8_pkg::block_t result;

  assign sdata[0].w    = {in_pair_7, in_pair_6, in_pair_5, in_pair_4,
                          in_pair_3, in_pair_2, in_pair_1, in_pair_0};
  assign sdata[0].orig = sdata[0].w;
  assign svalid[0]     = in_valid;
  assign in_ready      = sready[0];

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    sal8_step #(
      .ROW  (1'((s / 4) % 2)),
      .STEP (s % 4)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (svalid[s]),
      .in_ready  (sready[s]),
      .in_data   (sdata[s]),
      .out_valid (svalid[s+1]),
      .out_ready (sready[s+1]),
      .out_data  (sdata[s+1])
    );
  end

  sal8_fin u_fin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (svalid[NSTEP]),
    .in_ready  (sready[NSTEP]),
    .in_data   (sdata[NSTEP]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (result)
  );

  assign out_pair_0 = {result[1],  result[0]};
  assign out_pair_1 = {result[3],  result[2]};
  assign out_pair_2 = {result[5],  result[4]};
  assign out_pair_3 = {result[7],  result[6]};
  assign out_pair_4 = {result[9],  result[8]};
  assign out_pair_5 = {result[11], result[10]};
  assign out_pair_6 = {result[13], result[12]};
  assign out_pair_7 = {result[15], result[14]};

`ifndef SYNTHESIS
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output register is empty");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input not ready while output is being taken");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&svalid[NSTEP:1]))
    else $error("input stalled with an empty stage in the pipeline");
`endif

endmodule

>>> hdl/sal8_step.sv
// sal8_step: one registered add-rotate-xor step applied to all four quarter-rounds.
// Depends on sal8_pkg.
module sal8_step #(
  parameter bit ROW  = 1'b0,
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sal8_pkg::stage_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sal8_pkg::stage_t out_data
);

  localparam int TGT = (STEP + 1) % 4;
  localparam int SB  = (STEP + 3) % 4;

  sal8_pkg::stage_t data_next;

  always_comb begin
    data_next = in_data;
    for (int q = 0; q < 4; q++) begin
      data_next.w[sal8_pkg::QR_IDX[ROW][q][TGT]] =
        in_data.w[sal8_pkg::QR_IDX[ROW][q][TGT]] ^
        sal8_pkg::rotl(in_data.w[sal8_pkg::QR_IDX[ROW][q][STEP]] +
                       in_data.w[sal8_pkg::QR_IDX[ROW][q][SB]],
                       sal8_pkg::ROT[STEP]);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> hdl/sal8_fin.sv
// sal8_fin: final feed-forward stage, adds the original words back and holds the result.
// Depends on sal8_pkg.
module sal8_fin (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sal8_pkg::stage_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sal8_pkg::block_t out_data
);

  sal8_pkg::block_t sum_next;

  always_comb begin
    for (int i = 0; i < sal8_pkg::WORDS; i++) begin
      sum_next[i] = in_data.w[i] + in_data.orig[i];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= sum_next;
    end
  end

endmodule
